/* rtl/pimt_pkg.sv */
// pimt_pkg: shared widths, opcodes and breakpoint tables for the pollutant
// index max tracker. No dependencies; imported by every rtl file.
package pimt_pkg;

  // Field widths of the transfer channels
  localparam int OPCODE_W = 1;
  localparam int POLL_W   = 3;
  localparam int CONC_W   = 17;
  localparam int IDX_W    = 13;

  // Default fraction bits of concentration and index
  localparam int FRAC_BITS_DEF = 4;

  // Table shape
  localparam int NUM_POLL = 6;
  localparam int NUM_BP   = 7;
  localparam int SEG_W    = 3;

  // Index saturation level
  localparam int IDX_SAT = 8191;

  // Serial multiply operands: segment offset times index step
  localparam int NUM_W  = 16;
  localparam int STEP_W = 7;
  localparam int ACC_W  = NUM_W + STEP_W;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_TAKE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  // Breakpoints in half units so that 57.5 stays exact; negative marks a gap
  localparam int BP_HALF [NUM_POLL][NUM_BP] = '{
    '{  0,  24,  110,  300,  500,  700, 1000 },
    '{  0, 100,  300,  700,  840, 1000, 1200 },
    '{  0, 160,  730, 1600, 3200, 4200, 5240 },
    '{  0,  10,   20,   34,   68,   92,  115 },
    '{  0, 236,  314,  470, 1570, 1960, 2360 },
    '{ -2,  -2,   -2, 2260, 4520, 6000, 7500 }
  };

  // Breakpoint scaled to the fixed-point grid, truncated toward zero
  function automatic int bp_val(input int p, input int k, input int frac);
    int x;
    x = BP_HALF[p][k] * (1 << frac);
    return x / 2;
  endfunction

  // Index at the lower end of a segment
  function automatic logic [8:0] seg_base(input logic [SEG_W-1:0] k);
    logic [8:0] r;
    unique case (k)
      3'd0:    r = 9'd0;
      3'd1:    r = 9'd50;
      3'd2:    r = 9'd100;
      3'd3:    r = 9'd200;
      3'd4:    r = 9'd300;
      3'd5:    r = 9'd400;
      3'd6:    r = 9'd500;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Index span of a segment
  function automatic logic [STEP_W-1:0] seg_step(input logic [SEG_W-1:0] k);
    return (k < 3'd2) ? STEP_W'(50) : STEP_W'(100);
  endfunction

endpackage

/* rtl/pimt_muldiv.sv */
// pimt_muldiv: bit-serial shift-add multiplier followed by a restoring
// radix-2 divider. Depends on pimt_pkg.
module pimt_muldiv #(
  parameter int FRAC_BITS = pimt_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pimt_pkg::NUM_W-1:0]     num,
  input  logic [pimt_pkg::STEP_W-1:0]    step,
  input  logic [11+FRAC_BITS:0]          den,
  output logic                           done,
  output logic [6+FRAC_BITS:0]           quot
);
  import pimt_pkg::*;

  localparam int DEN_W = 12 + FRAC_BITS;
  localparam int QUO_W = 7 + FRAC_BITS;
  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t          state_r, state_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;

  logic [ACC_W-1:0]   acc_sum;
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     rem_dif;
  logic               rem_geq;

  // One multiplier bit per cycle, MSB first
  assign acc_sum = {acc_r[ACC_W-2:0], 1'b0} +
                   (step_r[STEP_W-1] ? ACC_W'(num_r) : '0);

  // One quotient bit per cycle; dividend low bits shift out of quo_r
  assign rem_sh  = {rem_r, quo_r[QUO_W-1]};
  assign rem_geq = (rem_sh >= {1'b0, den_r});
  assign rem_dif = rem_sh - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    step_nxt  = step_r;
    den_nxt   = den_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      MD_IDLE: begin
        if (start) begin
          num_nxt   = num;
          step_nxt  = step;
          den_nxt   = den;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_nxt  = acc_sum;
        step_nxt = {step_r[STEP_W-2:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEP_W - 1)) begin
          // Upper product bits seed the remainder, lower bits feed the divider
          rem_nxt   = DEN_W'(acc_sum[ACC_W-1:STEP_W]);
          quo_nxt   = QUO_W'(acc_sum[STEP_W-1:0]) << FRAC_BITS;
          cnt_nxt   = '0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_nxt = rem_geq ? DEN_W'(rem_dif) : DEN_W'(rem_sh);
        quo_nxt = {quo_r[QUO_W-2:0], rem_geq};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    step_r <= step_nxt;
    den_r  <= den_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* rtl/pollutant_index_max_tracker_core.sv */
// Read item: result valid the cycle after the transfer; the next item is taken
// once the result is taken or while out_ready is high. Take item: a search
// step, then the serial multiply and the restoring divide in pimt_muldiv, then
// the compare with the running maximum; unknown pollutant codes are dropped and
// misses skip the multiply and divide. One item at a time. Synchronous active-low
// reset clears the running maximum and the output valid flag; no clearing pass.
module pollutant_index_max_tracker_core #(
  parameter int FRAC_BITS = pimt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pimt_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [pimt_pkg::POLL_W-1:0]         in_pollutant,
  input  logic signed [pimt_pkg::CONC_W-1:0]  in_concentration,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pimt_pkg::IDX_W-1:0]          out_index_value
);
  import pimt_pkg::*;

  localparam int BP_W    = 13 + FRAC_BITS;
  localparam int CMP_W   = (BP_W > CONC_W) ? BP_W : CONC_W;
  localparam int DEN_W   = 12 + FRAC_BITS;
  localparam int QUO_W   = 7 + FRAC_BITS;
  localparam int VAL_W   = (10 + FRAC_BITS > IDX_W + 1) ? 10 + FRAC_BITS : IDX_W + 1;
  localparam int TOP_IDX = 500 << FRAC_BITS;
  localparam int TOP_SAT = (TOP_IDX > IDX_SAT) ? IDX_SAT : TOP_IDX;
  localparam logic [SEG_W-1:0] TOP_SEG = SEG_W'(NUM_BP - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_CALC = 3'b100
  } pimt_state_t;

  pimt_state_t              state_r, state_nxt;
  logic [POLL_W-1:0]        poll_r, poll_nxt;
  logic signed [CONC_W-1:0] conc_r, conc_nxt;
  logic [SEG_W-1:0]         seg_r, seg_nxt;
  logic [IDX_W-1:0]         max_r, max_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;

  logic signed [CMP_W-1:0]  bp_tab [NUM_POLL][NUM_BP];
  logic signed [CMP_W-1:0]  conc_ext;
  logic signed [CMP_W-1:0]  bp_lo, bp_hi;
  logic                     hit;
  logic [SEG_W-1:0]         seg;
  logic [SEG_W-1:0]         seg_up;
  logic [NUM_W-1:0]         md_num;
  logic [DEN_W-1:0]         md_den;
  logic                     md_start;
  logic                     md_done;
  logic [QUO_W-1:0]         md_quot;
  logic [VAL_W-1:0]         val;
  logic [IDX_W-1:0]         val_sat;
  logic                     in_xfer;

  // Build breakpoint table on the fixed-point grid
  for (genvar gp = 0; gp < NUM_POLL; gp++) begin : g_poll
    for (genvar gk = 0; gk < NUM_BP; gk++) begin : g_bp
      assign bp_tab[gp][gk] = CMP_W'(bp_val(gp, gk, FRAC_BITS));
    end
  end

  // Find the highest breakpoint strictly below the reading
  always_comb begin
    conc_ext = CMP_W'(conc_r);
    hit      = 1'b0;
    seg      = '0;
    for (int k = 0; k < NUM_BP; k++) begin
      if (conc_ext > bp_tab[poll_r][k]) begin
        hit = 1'b1;
        seg = SEG_W'(k);
      end
    end
  end

  assign seg_up = (seg == TOP_SEG) ? seg : seg + 1'b1;
  assign bp_lo  = bp_tab[poll_r][seg];
  assign bp_hi  = bp_tab[poll_r][seg_up];
  assign md_num = NUM_W'(conc_ext - bp_lo);
  assign md_den = DEN_W'(bp_hi - bp_lo);

  // Interpolate only inside a segment whose lower breakpoint is not a gap
  assign md_start = (state_r == ST_SRCH) && hit && (seg != TOP_SEG) &&
                    !bp_lo[CMP_W-1];

  pimt_muldiv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .num   (md_num),
    .step  (seg_step(seg)),
    .den   (md_den),
    .done  (md_done),
    .quot  (md_quot)
  );

  // Segment base plus interpolated part, saturated to the index width
  assign val     = (VAL_W'(seg_base(seg_r)) << FRAC_BITS) + VAL_W'(md_quot);
  assign val_sat = (val > VAL_W'(IDX_SAT)) ? IDX_W'(IDX_SAT) : IDX_W'(val);

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    poll_nxt      = poll_r;
    conc_nxt      = conc_r;
    seg_nxt       = seg_r;
    max_nxt       = max_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;

    // Drop the result once the transfer completes
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_READ) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = max_r;
            max_nxt       = '0;
          end else if (in_pollutant < POLL_W'(NUM_POLL)) begin
            poll_nxt  = in_pollutant;
            conc_nxt  = in_concentration;
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        seg_nxt   = seg;
        state_nxt = md_start ? ST_CALC : ST_IDLE;
        // Above the top breakpoint the index is forced, not maxed
        if (hit && (seg == TOP_SEG)) begin
          max_nxt = IDX_W'(TOP_SAT);
        end
      end
      ST_CALC: begin
        if (md_done) begin
          if (val_sat > max_r) begin
            max_nxt = val_sat;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    poll_r    <= poll_nxt;
    conc_r    <= conc_nxt;
    seg_r     <= seg_nxt;
    out_idx_r <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_index_value = out_idx_r;

endmodule

/* rtl/pimt_checker.sv */
// pimt_checker: port-level assertions for the tracker core, attached by bind.
// Depends on pimt_pkg and pollutant_index_max_tracker_core.
module pimt_checker #(
  parameter int FRAC_BITS = pimt_pkg::FRAC_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [pimt_pkg::OPCODE_W-1:0]       in_opcode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [pimt_pkg::IDX_W-1:0]          out_index_value
);
  import pimt_pkg::*;

  localparam int TOP_IDX = 500 << FRAC_BITS;
  localparam int MAX_IDX = (TOP_IDX > IDX_SAT) ? IDX_SAT : TOP_IDX;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index_value))
    else $error("result changed while stalled");

  // Index never exceeds the top of the scale
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index_value <= IDX_W'(MAX_IDX))
    else $error("index above top of scale");

  // A read transfer yields a result in the next cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_READ |=> out_valid)
    else $error("read produced no result");

  // Take no item while a result is stalled
  a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Reset clears the result valid flag
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pollutant_index_max_tracker_core pimt_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_pimt_checker (.*);
